>>> sv/bfe_pkg.sv
package bfe_pkg;

  // field widths
  localparam int MS_W       = 16;
  localparam int PCT_W      = 7;
  localparam int DUTY_OUT_W = 10;
  localparam int BLEND_W    = 8;
  localparam int CMD_W      = 3;
  localparam int TIME_W     = 32;
  localparam int LVL_W      = 8;
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 4;

  // fixed values
  localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
  localparam logic [BLEND_W-1:0] BLEND_FULL = 8'd255;

  // register reset values
  localparam logic [MS_W-1:0]  FADE_DOWN_RST = 16'd5000;
  localparam logic [MS_W-1:0]  FADE_UP_RST   = 16'd1000;
  localparam logic [PCT_W-1:0] DIM_RST       = 7'd30;
  localparam logic [PCT_W-1:0] BRIGHT_RST    = 7'd100;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FADE_DIM    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FADE_BRIGHT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_LEVEL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL      = 3'd4;

  // register indexes (word address)
  localparam logic [1:0] REG_FADE_DOWN = 2'd0;
  localparam logic [1:0] REG_FADE_UP   = 2'd1;
  localparam logic [1:0] REG_DIM       = 2'd2;
  localparam logic [1:0] REG_BRIGHT    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FROM,
    S_TO,
    S_STEP,
    S_BLEND,
    S_SET,
    S_APPLY,
    S_LEVEL,
    S_WAIT,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_FROM,
    OP_TO,
    OP_INTERP,
    OP_BLEND,
    OP_SET,
    OP_LEVEL
  } op_t;

endpackage

>>> sv/bfe_muldiv.sv
// (a * b + addend) / divisor, one quotient bit per cycle
module bfe_muldiv import bfe_pkg::*; #(
  parameter int QW = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [QW-1:0]   a,
  input  logic [MS_W-1:0] b,
  input  logic [QW-1:0]   addend,
  input  logic [MS_W-1:0] divisor,
  output logic            done,
  output logic [QW-1:0]   quotient
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [MS_W-1:0]  rem;
  logic [QW-1:0]    low;
  logic [MS_W-1:0]  dvs;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  logic [MS_W:0]    trial;
  logic             ge;
  logic [MS_W:0]    diff;
  logic [MS_W+QW-1:0] prod;

  // product and addend land in the remainder / dividend shift pair
  assign prod  = (MS_W+QW)'(a) * (MS_W+QW)'(b) + (MS_W+QW)'(addend);

  // one restoring step
  assign trial = {rem, low[QW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= prod[MS_W+QW-1:QW];
      low <= prod[QW-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
      low <= {low[QW-2:0], ge};
    end
  end

  assign quotient = low;

endmodule

>>> sv/backlight_fade_engine.sv
// Backlight fade engine: linear PWM duty fade between a bright and a dim level.
// Input channel (in_valid/in_ready) takes one command with a millisecond time
// stamp and a level percent; the output channel (out_valid/out_ready) returns
// exactly one result per command: duty, write strobe, crossfade blend and flags.
// Registers sit on an APB-style port: fade_down_ms at 0x0, fade_up_ms at 0x4,
// dim_percent at 0x8, bright_percent at 0xC; write them only while idle.
// One command is worked on at a time. Every multiply/divide goes through a
// single bit-serial divider with a W-bit quotient, W being the
// width of DUTY_MAX (10 bits by default). A mid-fade tick that moves the duty
// costs three operations (interpolation, blend, percent readback); a fade
// start adds two more for the end-point duties; set level costs up to two
// and cancel and ignored commands none.
// The result waits in an output register; a new command is taken once the
// previous result is loaded there, and a stalled receiver holds the engine
// only when a further result is ready to be loaded.
// Synchronous reset restores register defaults, stops any fade, marks the
// duty as not yet applied and sets the percent readback to 100.
module backlight_fade_engine import bfe_pkg::*; #(
  parameter int DUTY_MAX = 1023
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready,
  // command channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [TIME_W-1:0]     time_ms,
  input  logic [LVL_W-1:0]      level_percent,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_OUT_W-1:0] duty,
  output logic                  duty_write,
  output logic [BLEND_W-1:0]    blend,
  output logic                  blend_on_dim_view,
  output logic                  fade_done,
  output logic                  fade_running,
  output logic [PCT_W-1:0]      brightness_percent
);

  localparam int DW = $clog2(DUTY_MAX + 1);
  localparam logic [DW-1:0]   DUTY_MAX_Q  = DW'(DUTY_MAX);
  localparam logic [DW-1:0]   DUTY_HALF_Q = DW'(DUTY_MAX / 2);
  localparam logic [MS_W-1:0] DUTY_MAX_D  = MS_W'(DUTY_MAX);

  // configuration
  logic [MS_W-1:0]  fade_down_ms;
  logic [MS_W-1:0]  fade_up_ms;
  logic [PCT_W-1:0] dim_percent;
  logic [PCT_W-1:0] bright_percent;

  // fade state
  state_t state, state_next;
  op_t    op_r;
  logic              fading;
  logic              toward_dim;
  logic              is_dimmed;
  logic [TIME_W-1:0] fade_start_time;
  logic [DW-1:0]     from_duty;
  logic [DW-1:0]     to_duty;
  logic [DW-1:0]     applied_duty;
  logic              applied_valid;
  logic [PCT_W-1:0]  level_now;

  // per-command scratch
  logic [TIME_W-1:0]  now_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [MS_W-1:0]    el_r;
  logic [DW-1:0]      cand;
  logic [BLEND_W-1:0] blend_r;
  logic               wrote_r;
  logic               stepped_r;
  logic               step_td_r;
  logic               done_r;

  // divider hookup
  logic            div_start;
  logic            div_done;
  logic [DW-1:0]   div_a;
  logic [MS_W-1:0] div_b;
  logic [DW-1:0]   div_add;
  logic [MS_W-1:0] div_d;
  logic [DW-1:0]   div_q;

  logic              cfg_wr;
  logic              fade_ok;
  logic              in_xfer;
  logic              load_out;
  logic [PCT_W-1:0]  cur_pct;
  logic [PCT_W-1:0]  dim_c;
  logic [PCT_W-1:0]  bright_c;
  logic [PCT_W-1:0]  from_pct;
  logic [PCT_W-1:0]  to_pct;
  logic [PCT_W-1:0]  lvl_c;
  logic [MS_W-1:0]   dur;
  logic [TIME_W-1:0] el_raw;
  logic              el_end;
  logic [MS_W-1:0]   el_c;
  logic              rising;
  logic [DW-1:0]     span;
  logic [DW+DUTY_OUT_W-1:0] duty_ext;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_down_ms   <= FADE_DOWN_RST;
      fade_up_ms     <= FADE_UP_RST;
      dim_percent    <= DIM_RST;
      bright_percent <= BRIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FADE_DOWN: fade_down_ms   <= pwdata[MS_W-1:0];
        REG_FADE_UP:   fade_up_ms     <= pwdata[MS_W-1:0];
        REG_DIM:       dim_percent    <= pwdata[PCT_W-1:0];
        REG_BRIGHT:    bright_percent <= pwdata[PCT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FADE_DOWN: prdata = CFG_DW'(fade_down_ms);
      REG_FADE_UP:   prdata = CFG_DW'(fade_up_ms);
      REG_DIM:       prdata = CFG_DW'(dim_percent);
      REG_BRIGHT:    prdata = CFG_DW'(bright_percent);
    endcase
  end

  // command decode at the input transfer
  assign in_xfer = in_valid & in_ready;
  assign fade_ok = ~fading & (((command == CMD_FADE_DIM) & ~is_dimmed) |
                              ((command == CMD_FADE_BRIGHT) & is_dimmed));

  // percent clamps and fade end points
  assign cur_pct  = (level_now > PCT_FULL) ? PCT_FULL : level_now;
  assign dim_c    = (dim_percent > PCT_FULL) ? PCT_FULL : dim_percent;
  assign bright_c = (bright_percent > PCT_FULL) ? PCT_FULL : bright_percent;
  assign from_pct = (toward_dim || cur_pct >= dim_c) ? cur_pct : dim_c;
  assign to_pct   = toward_dim ? dim_c : bright_c;
  assign lvl_c    = (lvl_r > LVL_W'(PCT_FULL)) ? PCT_FULL : lvl_r[PCT_W-1:0];

  // elapsed time, wrapped and clamped to the duration
  assign dur    = toward_dim ? fade_down_ms : fade_up_ms;
  assign el_raw = now_r - fade_start_time;
  assign el_end = (dur == '0) || (el_raw >= TIME_W'(dur));
  assign el_c   = el_end ? dur : el_raw[MS_W-1:0];
  assign rising = to_duty >= from_duty;
  assign span   = rising ? (to_duty - from_duty) : (from_duty - to_duty);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (fade_ok) begin
            state_next = S_FROM;
          end else begin
            case (command) inside
              CMD_TICK, CMD_FADE_DIM, CMD_FADE_BRIGHT:
                state_next = fading ? S_STEP : S_OUT;
              CMD_SET_LEVEL: state_next = S_SET;
              default:       state_next = S_OUT;
            endcase
          end
        end
      end
      S_FROM:  state_next = S_WAIT;
      S_TO:    state_next = S_WAIT;
      S_STEP:  state_next = el_end ? S_APPLY : S_WAIT;
      S_BLEND: state_next = S_WAIT;
      S_SET:   state_next = S_WAIT;
      S_APPLY: state_next = (applied_valid && cand == applied_duty) ? S_OUT : S_LEVEL;
      S_LEVEL: state_next = S_WAIT;
      S_WAIT: begin
        if (div_done) begin
          unique case (op_r)
            OP_FROM:   state_next = S_TO;
            OP_TO:     state_next = S_STEP;
            OP_INTERP: state_next = S_BLEND;
            OP_BLEND:  state_next = S_APPLY;
            OP_SET:    state_next = S_APPLY;
            OP_LEVEL:  state_next = S_OUT;
          endcase
        end
      end
      S_OUT: state_next = (!out_valid || out_ready) ? S_IDLE : S_OUT;
    endcase
  end

  // state outputs and divider operands
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    div_a     = DUTY_MAX_Q;
    div_b     = MS_W'(from_pct);
    div_add   = '0;
    div_d     = MS_W'(PCT_FULL);
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_FROM: div_start = 1'b1;
      S_TO: begin
        div_start = 1'b1;
        div_b     = MS_W'(to_pct);
      end
      S_SET: begin
        div_start = 1'b1;
        div_b     = MS_W'(lvl_c);
      end
      S_STEP: begin
        div_start = ~el_end;
        div_a     = span;
        div_b     = el_c;
        div_d     = dur;
      end
      S_BLEND: begin
        div_start = 1'b1;
        div_a     = DW'(BLEND_FULL);
        div_b     = el_r;
        div_d     = dur;
      end
      S_LEVEL: begin
        div_start = 1'b1;
        div_a     = applied_duty;
        div_b     = MS_W'(PCT_FULL);
        div_add   = DUTY_HALF_Q;
        div_d     = DUTY_MAX_D;
      end
      S_OUT:   load_out = ~out_valid | out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // fade state and per-command results
  always_ff @(posedge clk) begin
    if (rst) begin
      op_r            <= OP_FROM;
      fading          <= 1'b0;
      toward_dim      <= 1'b0;
      is_dimmed       <= 1'b0;
      fade_start_time <= '0;
      from_duty       <= '0;
      to_duty         <= '0;
      applied_duty    <= '0;
      applied_valid   <= 1'b0;
      level_now       <= PCT_FULL;
      wrote_r         <= 1'b0;
      stepped_r       <= 1'b0;
      step_td_r       <= 1'b0;
      done_r          <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            now_r     <= time_ms;
            lvl_r     <= level_percent;
            wrote_r   <= 1'b0;
            stepped_r <= 1'b0;
            done_r    <= 1'b0;
            if (fade_ok) begin
              applied_valid   <= 1'b0;
              fading          <= 1'b1;
              toward_dim      <= (command == CMD_FADE_DIM);
              fade_start_time <= time_ms;
            end else if (command == CMD_CANCEL) begin
              fading     <= 1'b0;
              toward_dim <= 1'b0;
            end
          end
        end
        S_FROM: op_r <= OP_FROM;
        S_TO:   op_r <= OP_TO;
        S_SET:  op_r <= OP_SET;
        S_STEP: begin
          op_r      <= OP_INTERP;
          el_r      <= el_c;
          stepped_r <= 1'b1;
          step_td_r <= toward_dim;
          if (el_end) begin
            cand       <= to_duty;
            blend_r    <= toward_dim ? BLEND_FULL : '0;
            done_r     <= 1'b1;
            is_dimmed  <= toward_dim;
            fading     <= 1'b0;
            toward_dim <= 1'b0;
          end
        end
        S_BLEND: op_r <= OP_BLEND;
        S_APPLY: begin
          if (!(applied_valid && cand == applied_duty)) begin
            applied_duty  <= cand;
            applied_valid <= 1'b1;
            wrote_r       <= 1'b1;
          end
        end
        S_LEVEL: op_r <= OP_LEVEL;
        S_WAIT: begin
          if (div_done) begin
            unique case (op_r)
              OP_FROM:   from_duty <= div_q;
              OP_TO:     to_duty   <= div_q;
              OP_INTERP: cand      <= rising ? (from_duty + div_q) : (from_duty - div_q);
              OP_BLEND:  blend_r   <= toward_dim ? div_q[BLEND_W-1:0]
                                                 : (BLEND_FULL - div_q[BLEND_W-1:0]);
              OP_SET:    cand      <= div_q;
              OP_LEVEL:  level_now <= div_q[PCT_W-1:0];
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  bfe_muldiv #(
    .QW(DW)
  ) u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .a        (div_a),
    .b        (div_b),
    .addend   (div_add),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // result register
  assign duty_ext = {{DUTY_OUT_W{1'b0}}, applied_duty};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      duty               <= duty_ext[DUTY_OUT_W-1:0];
      duty_write         <= wrote_r;
      blend              <= stepped_r ? blend_r : (is_dimmed ? BLEND_FULL : '0);
      blend_on_dim_view  <= stepped_r & ~step_td_r;
      fade_done          <= done_r;
      fade_running       <= fading;
      brightness_percent <= level_now;
    end
  end

endmodule

>>> sv/bfe_checker.sv
module bfe_checker import bfe_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DUTY_OUT_W-1:0] duty,
  input logic                  blend_on_dim_view,
  input logic                  fade_done,
  input logic                  fade_running,
  input logic [PCT_W-1:0]      brightness_percent
);

  // one command at a time: ready drops after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a command is in progress");

  // a finished fade is never still running
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(fade_done && fade_running))
    else $error("fade reported done and running");

  // an unfinished step toward bright keeps the fade running
  a_step_runs: assert property (@(posedge clk) disable iff (rst)
    (out_valid && blend_on_dim_view && !fade_done) |-> fade_running)
    else $error("fade step toward bright without running fade");

  // percent readback stays in range
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (brightness_percent <= PCT_FULL))
    else $error("brightness percent above full scale");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(duty)))
    else $error("result changed while stalled");

endmodule

bind backlight_fade_engine bfe_checker u_bfe_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .duty               (duty),
  .blend_on_dim_view  (blend_on_dim_view),
  .fade_done          (fade_done),
  .fade_running       (fade_running),
  .brightness_percent (brightness_percent)
);

>>> test/tb_backlight_fade_engine.sv
`timescale 1ns / 1ps

module tb_backlight_fade_engine;
  import bfe_pkg::*;

  localparam int DUTY_TOP = 1023;

  // command codes the engine must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct {
    logic [DUTY_OUT_W-1:0] duty;
    logic                  duty_write;
    logic [BLEND_W-1:0]    blend;
    logic                  on_dim_view;
    logic                  done;
    logic                  running;
    logic [PCT_W-1:0]      pct;
  } fade_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command = CMD_TICK;
  logic [TIME_W-1:0] time_ms = '0;
  logic [LVL_W-1:0]  level_percent = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DUTY_OUT_W-1:0] duty;
  logic                  duty_write;
  logic [BLEND_W-1:0]    blend;
  logic                  blend_on_dim_view;
  logic                  fade_done;
  logic                  fade_running;
  logic [PCT_W-1:0]      brightness_percent;

  backlight_fade_engine #(
    .DUTY_MAX(DUTY_TOP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .time_ms(time_ms),
    .level_percent(level_percent),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .duty(duty),
    .duty_write(duty_write),
    .blend(blend),
    .blend_on_dim_view(blend_on_dim_view),
    .fade_done(fade_done),
    .fade_running(fade_running),
    .brightness_percent(brightness_percent)
  );

  always #1 clk = ~clk;

  // mirror of the fade engine registers and state
  int unsigned down_ms_m = FADE_DOWN_RST;
  int unsigned up_ms_m = FADE_UP_RST;
  int unsigned dim_pct_m = DIM_RST;
  int unsigned bright_pct_m = BRIGHT_RST;
  bit          fading_m = 1'b0;
  bit          toward_dim_m = 1'b0;
  bit          dimmed_m = 1'b0;
  logic [31:0] start_time_m = '0;
  int unsigned from_duty_m = 0;
  int unsigned to_duty_m = 0;
  int unsigned applied_duty_m = 0;
  bit          applied_valid_m = 1'b0;
  int unsigned level_now_m = PCT_FULL;

  fade_result_t fade_results_due[$];
  int error_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic int unsigned pct_limit(input int unsigned p);
    return (p > PCT_FULL) ? PCT_FULL : p;
  endfunction

  function automatic int unsigned pct_to_duty(input int unsigned p);
    return (DUTY_TOP * pct_limit(p)) / PCT_FULL;
  endfunction

  // write the pwm only when the duty moves, or after a fade start cleared it
  function automatic bit apply_duty(input int unsigned d);
    if (d > DUTY_TOP) d = DUTY_TOP;
    if (applied_valid_m && d == applied_duty_m) return 1'b0;
    applied_duty_m = d;
    applied_valid_m = 1'b1;
    level_now_m = (d * PCT_FULL + DUTY_TOP / 2) / DUTY_TOP;
    return 1'b1;
  endfunction

  // advance the mirror by one command and return the result it produces
  function automatic fade_result_t fade_engine_step(input logic [CMD_W-1:0] cmd,
                                                    input logic [31:0] now,
                                                    input logic [LVL_W-1:0] lvl);
    fade_result_t r;
    int unsigned cur, lo, dur, target, blend_v;
    logic [31:0] el;
    longint unsigned span;
    bit wrote, stepped, done, on_dim;
    wrote = 1'b0;
    stepped = 1'b0;
    done = 1'b0;
    on_dim = 1'b0;
    blend_v = 0;
    // fade start, set level, cancel
    if ((cmd == CMD_FADE_DIM && !fading_m && !dimmed_m) ||
        (cmd == CMD_FADE_BRIGHT && !fading_m && dimmed_m)) begin
      cur = pct_limit(level_now_m);
      applied_valid_m = 1'b0;
      fading_m = 1'b1;
      toward_dim_m = (cmd == CMD_FADE_DIM);
      start_time_m = now;
      if (toward_dim_m) begin
        from_duty_m = pct_to_duty(cur);
        to_duty_m = pct_to_duty(dim_pct_m);
      end else begin
        lo = pct_limit(dim_pct_m);
        if (cur < lo) cur = lo;
        from_duty_m = pct_to_duty(cur);
        to_duty_m = pct_to_duty(bright_pct_m);
      end
    end else if (cmd == CMD_SET_LEVEL) begin
      wrote = apply_duty(pct_to_duty(lvl));
    end else if (cmd == CMD_CANCEL) begin
      fading_m = 1'b0;
      toward_dim_m = 1'b0;
    end
    // fade step on ticks and on fade commands
    if (fading_m && cmd <= CMD_FADE_BRIGHT) begin
      dur = toward_dim_m ? down_ms_m : up_ms_m;
      el = now - start_time_m;
      if (el > dur) el = dur;
      stepped = 1'b1;
      if (dur == 0 || el >= dur) begin
        target = to_duty_m;
      end else if (to_duty_m >= from_duty_m) begin
        span = to_duty_m - from_duty_m;
        span = span * el / dur;
        target = from_duty_m + int'(span);
      end else begin
        span = from_duty_m - to_duty_m;
        span = span * el / dur;
        target = from_duty_m - int'(span);
      end
      wrote = apply_duty(target);
      if (dur == 0) blend_v = toward_dim_m ? BLEND_FULL : 0;
      else if (toward_dim_m) blend_v = (el * BLEND_FULL) / dur;
      else blend_v = BLEND_FULL - (el * BLEND_FULL) / dur;
      on_dim = !toward_dim_m;
      if (el >= dur) begin
        done = 1'b1;
        dimmed_m = toward_dim_m;
        fading_m = 1'b0;
        toward_dim_m = 1'b0;
      end
    end
    if (!stepped) begin
      blend_v = dimmed_m ? BLEND_FULL : 0;
      on_dim = 1'b0;
    end
    r.duty = applied_duty_m[DUTY_OUT_W-1:0];
    r.duty_write = wrote;
    r.blend = blend_v[BLEND_W-1:0];
    r.on_dim_view = on_dim;
    r.done = done;
    r.running = fading_m;
    r.pct = level_now_m[PCT_W-1:0];
    return r;
  endfunction

  // one command transfer, with an optional gap before it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [31:0] t,
                           input logic [LVL_W-1:0] lvl);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    time_ms <= t;
    level_percent <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fade_results_due.push_back(fade_engine_step(cmd, t, lvl));
    if (cmd <= CMD_CANCEL) items_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (fade_results_due.size() != 0) @(posedge clk);
  endtask

  // apb write: setup, then access
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FADE_DOWN: down_ms_m = value[MS_W-1:0];
      REG_FADE_UP:   up_ms_m = value[MS_W-1:0];
      REG_DIM:       dim_pct_m = value[PCT_W-1:0];
      REG_BRIGHT:    bright_pct_m = value[PCT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_ms();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      2: return 1;
      3: return $urandom_range(0, 65535);
      default: return $urandom_range(2, 400);
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return PCT_FULL;
      2: return 127;
      3: return $urandom_range(101, 127);
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  task automatic field_check(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    fade_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (fade_results_due.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual duty %0d",
                 $time, duty);
        error_count++;
      end else begin
        want = fade_results_due.pop_front();
        field_check("duty", want.duty, duty);
        field_check("duty_write", want.duty_write, duty_write);
        field_check("blend", want.blend, blend);
        field_check("blend_on_dim_view", want.on_dim_view, blend_on_dim_view);
        field_check("fade_done", want.done, fade_done);
        field_check("fade_running", want.running, fade_running);
        field_check("brightness_percent", want.pct, brightness_percent);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // power-up state, ignored codes, set level clamping, rejected fade
  task automatic test_levels_after_reset();
    send_item(CMD_TICK, 32'h0, 8'h0);
    send_item(CMD_CANCEL, 32'd5, 8'h0);
    send_item(CMD_UNUSED_LO, 32'd6, 8'hFF);
    send_item(CMD_UNUSED_HI, 32'd7, 8'h0);
    send_item(CMD_SET_LEVEL, 32'd10, 8'hFF);
    send_item(CMD_SET_LEVEL, 32'd11, 8'd100);
    send_item(CMD_SET_LEVEL, 32'd12, 8'd0);
    send_item(CMD_FADE_BRIGHT, 32'd13, 8'h0);
  endtask

  // full dim and bright fades across the time wrap, cancel, backward time
  task automatic test_fade_cycle();
    send_item(CMD_FADE_DIM, 32'hFFFF_FF00, 8'h0);
    send_item(CMD_FADE_DIM, 32'hFFFF_FFFF, 8'h0);
    send_item(CMD_SET_LEVEL, 32'hFFFF_FFFF, 8'd50);
    send_item(CMD_TICK, 32'h0000_0400, 8'h0);
    send_item(CMD_TICK, 32'h0000_2000, 8'h0);
    send_item(CMD_FADE_DIM, 32'h0000_2001, 8'h0);
    send_item(CMD_FADE_BRIGHT, 32'h0001_0000, 8'h0);
    send_item(CMD_TICK, 32'h0001_0000, 8'h0);
    send_item(CMD_CANCEL, 32'h0001_0001, 8'h0);
    send_item(CMD_FADE_BRIGHT, 32'h0002_0000, 8'h0);
    send_item(CMD_TICK, 32'h0001_0000, 8'h0);
  endtask

  // zero and maximum durations, percents above and at the range ends
  task automatic test_config_extremes();
    wait_results_drained();
    write_reg(REG_FADE_DOWN, 32'd0);
    write_reg(REG_FADE_UP, 32'd0);
    write_reg(REG_DIM, 32'd127);
    write_reg(REG_BRIGHT, 32'd0);
    send_item(CMD_FADE_DIM, 32'd100, 8'h0);
    send_item(CMD_FADE_BRIGHT, 32'd101, 8'h0);
    wait_results_drained();
    write_reg(REG_FADE_DOWN, 32'd65535);
    write_reg(REG_FADE_UP, 32'd65535);
    write_reg(REG_DIM, 32'd0);
    write_reg(REG_BRIGHT, 32'd127);
    send_item(CMD_SET_LEVEL, 32'd150, 8'd77);
    send_item(CMD_FADE_DIM, 32'd200, 8'h0);
    send_item(CMD_TICK, 32'd200 + 32'd32767, 8'h0);
    send_item(CMD_TICK, 32'd200 + 32'd65535, 8'h0);
    send_item(CMD_FADE_BRIGHT, 32'd70000, 8'h0);
    send_item(CMD_TICK, 32'd70000 + 32'd65534, 8'h0);
  endtask

  // fade sequences with random content, mixed with noise
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int stop, chunk_end, r, n_ticks;
    int unsigned step_span;
    logic [31:0] now_ms;
    logic [CMD_W-1:0] fade_cmd;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop = items_sent + n_items;
    now_ms = $urandom;
    while (items_sent < stop) begin
      // reprogram only with nothing outstanding
      wait_results_drained();
      write_reg(REG_FADE_DOWN, pick_ms());
      write_reg(REG_FADE_UP, pick_ms());
      write_reg(REG_DIM, pick_pct());
      write_reg(REG_BRIGHT, pick_pct());
      chunk_end = items_sent + 120;
      while (items_sent < chunk_end && items_sent < stop) begin
        if ($urandom_range(0, 99) < 75) begin
          // well-formed fade, sometimes in the wrong direction
          fade_cmd = dimmed_m ? CMD_FADE_BRIGHT : CMD_FADE_DIM;
          if ($urandom_range(0, 9) == 0)
            fade_cmd = dimmed_m ? CMD_FADE_DIM : CMD_FADE_BRIGHT;
          if ($urandom_range(0, 9) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
          send_item(fade_cmd, now_ms, LVL_W'($urandom_range(0, 255)));
          step_span = (fading_m && toward_dim_m ? down_ms_m : up_ms_m) / 3 + 2;
          n_ticks = $urandom_range(1, 12);
          repeat (n_ticks) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
              now_ms = now_ms + $urandom_range(0, step_span);
              send_item(CMD_TICK, now_ms, LVL_W'($urandom_range(0, 255)));
            end else if (r < 87) begin
              send_item(CMD_SET_LEVEL, now_ms,
                        LVL_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 100) :
                                                             $urandom_range(0, 255)));
            end else if (r < 92) begin
              send_item(CMD_CANCEL, now_ms, LVL_W'($urandom_range(0, 255)));
            end else if (r < 97) begin
              send_item(($urandom_range(0, 1) != 0) ? CMD_FADE_DIM : CMD_FADE_BRIGHT,
                        now_ms, LVL_W'($urandom_range(0, 255)));
            end else begin
              send_item(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), now_ms,
                        LVL_W'($urandom_range(0, 255)));
            end
          end
        end else begin
          // noise: any code, near or far time
          if ($urandom_range(0, 1) != 0) now_ms = now_ms + $urandom_range(0, 2000);
          send_item(CMD_W'($urandom_range(0, 7)),
                    ($urandom_range(0, 3) == 0) ? $urandom : now_ms,
                    LVL_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 100) :
                                                         $urandom_range(0, 255)));
        end
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 65;
    test_levels_after_reset();
    test_fade_cycle();
    test_config_extremes();
    test_random_traffic(14, 65, 660);
    test_random_traffic(65, 14, 660);
    test_random_traffic(0, 0, 660);
    wait_results_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
